@@ rtl/itc_pkg.sv @@
// Shared types and constants for the ignition timing controller.
// Holds the state and opcode enums, register indexes, band table and result layout.
// No dependencies; every other file refers to it by scoped names.
package itc_pkg;

   // Width of the quotients from the bit-serial divider, and its step count.
   localparam int QUOT_W    = 21;
   localparam int DIV_STEPS = 21;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SETTLE
   } state_type;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_ENCODER = 2'd1,
      OP_INDEX   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_INJ_HIGH   = 2'd0,
      CSR_INJ_LOW    = 2'd1,
      CSR_DWELL_BASE = 2'd2
   } csr_index_type;

   // Speed is 11250000 / period rounded down to tens, which equals
   // 10 * (1125000 / period), so the divider works on the smaller dividend.
   localparam logic [QUOT_W-1:0] RPM_DIVIDEND  = 21'd1125000;
   localparam logic [QUOT_W-1:0] LEAD_DIVIDEND = 21'd337500;
   localparam logic [QUOT_W-1:0] RPM_Q_MAX     = 21'd6553;
   localparam logic [15:0]       RPM_SAT       = 16'hFFFF;

   localparam logic [9:0] ANGLE_MAX = 10'd719;

   localparam logic [15:0] BAND_LOW_0 = 16'd250;
   localparam logic [15:0] BAND_LOW_1 = 16'd2250;
   localparam logic [15:0] BAND_LOW_2 = 16'd2750;
   localparam logic [15:0] BAND_LOW_3 = 16'd3250;
   localparam logic [15:0] BAND_LOW_4 = 16'd4000;
   localparam logic [15:0] BAND_TOP   = 16'd5750;

   localparam logic [9:0] SPARK_BAND_0 = 10'd711;
   localparam logic [9:0] SPARK_BAND_1 = 10'd710;
   localparam logic [9:0] SPARK_BAND_2 = 10'd709;
   localparam logic [9:0] SPARK_BAND_3 = 10'd706;
   localparam logic [9:0] SPARK_BAND_4 = 10'd705;
   localparam logic [9:0] SPARK_MIN    = 10'd705;
   localparam logic [9:0] SPARK_MAX    = 10'd711;

   localparam logic [15:0] DWELL_RESET      = 16'd615;
   localparam logic [9:0]  SPARK_RESET      = 10'd705;
   localparam logic [15:0] INJ_HIGH_RESET   = 16'd670;
   localparam logic [15:0] INJ_LOW_RESET    = 16'd180;
   localparam logic [15:0] DWELL_BASE_RESET = 16'd704;

   // Result beat, last field in the lowest bits.
   typedef struct packed {
      logic [2:0]  pad;
      logic [9:0]  spark_angle;
      logic [15:0] spark_count;
      logic        engine_stopped;
      logic [15:0] engine_rpm;
      logic [15:0] crank_angle;
      logic        injector_on;
      logic        coil_on;
   } rsp_type;

endpackage

@@ rtl/ignition_timing_controller_core.sv @@
// Ignition timing controller: event handling, bit-serial speed divider and result register.
// Depends on itc_pkg for types, constants and the result beat layout.
//
// Usage:
//   req channel: one beat per event. tuser carries the opcode (period tick,
//   encoder pulse, index pulse); tdata bit 0 carries engine_enable.
//   rsp channel: one beat per accepted event with coil, injector, crank angle,
//   speed, stopped flag, charge count and spark angle.
//   csr channel: writes injector window and dwell base registers; always ready.
//   The user writes it only while no event is in flight; the block does not enforce this.
// Event flow:
//   Each event passes through ST_SETTLE, which registers the result once the
//   output register is free, and the block accepts the next event only after
//   it returns to ST_IDLE, so it does not take a new event before it is through
//   with the last one. An index pulse that closes a period first passes through
//   ST_DIVIDE, a restoring divider that resolves one quotient bit per cycle.
//   The divider sets the worst case.
// Reset puts the engine in the stopped state with register defaults; no
//   result is pending afterwards.
// Stall: a result waits in the output register while rsp_tready is low; the
//   next event is still accepted, and its result is held back until the
//   register frees.
module ignition_timing_controller_core #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] engine_enable, [7:1] zero
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [0] coil_on, [1] injector_on, [17:2] crank_angle,
                                    // [33:18] engine_rpm, [34] engine_stopped,
                                    // [50:35] spark_count, [60:51] spark_angle, [63:61] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int W  = COUNTER_WIDTH;
   localparam int QW = itc_pkg::QUOT_W;

   itc_pkg::state_type  state_ff, state_in;
   itc_pkg::opcode_type req_op;
   itc_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic [W-1:0]  timer_ff, timer_in;
   logic          running_ff, running_in;
   logic [W-1:0]  period_ff, period_in;
   logic          stopped_ff, stopped_in;
   logic [9:0]    angle_ff, angle_in;
   logic [15:0]   dwell_cmp_ff, dwell_cmp_in;
   logic [15:0]   dwell_next_ff, dwell_next_in;
   logic [9:0]    spark_ff, spark_in;
   logic          coil_ff, coil_in;
   logic [15:0]   charge_ff, charge_in;
   logic [15:0]   inj_high_ff, inj_high_in;
   logic [15:0]   inj_low_ff, inj_low_in;
   logic [15:0]   dwell_base_ff, dwell_base_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [itc_pkg::STEP_W-1:0] step_ff, step_in;

   // Divider datapath: dividend shift registers, partial remainders and quotients.
   logic [QW-1:0] num_rpm_ff, num_rpm_in, num_lead_ff, num_lead_in;
   logic [QW-1:0] q_rpm_ff, q_rpm_in, q_lead_ff, q_lead_in;
   logic [W-1:0]  rem_rpm_ff, rem_rpm_in, rem_lead_ff, rem_lead_in;
   logic [W:0]    trial_rpm, trial_lead, diff_rpm, diff_lead;
   logic          ge_rpm, ge_lead;

   logic          req_fire, slot_free, closes_period;
   logic          enable_bit;
   logic [9:0]    angle_next;
   logic [15:0]   rpm_calc, rpm_now, dwell_target;
   logic          band_hit;
   logic [9:0]    band_spark;

   assign req_op     = itc_pkg::opcode_type'(req_tuser);
   assign enable_bit = req_tdata[0];
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign closes_period = (req_op == itc_pkg::OP_INDEX) && running_ff;
   assign angle_next = angle_ff + 10'd1;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // One restoring step per cycle on each dividend.
   always_comb begin
      trial_rpm  = {rem_rpm_ff, num_rpm_ff[QW-1]};
      trial_lead = {rem_lead_ff, num_lead_ff[QW-1]};
      diff_rpm   = trial_rpm - {1'b0, period_ff};
      diff_lead  = trial_lead - {1'b0, period_ff};
      ge_rpm     = trial_rpm >= {1'b0, period_ff};
      ge_lead    = trial_lead >= {1'b0, period_ff};
   end

   // Speed and dwell start from the stored quotients. A zero period gives
   // all-ones quotients, which saturate the speed and floor the dwell at zero.
   always_comb begin
      if (q_rpm_ff > itc_pkg::RPM_Q_MAX) begin
         rpm_calc = itc_pkg::RPM_SAT;
      end else begin
         rpm_calc = {q_rpm_ff[12:0], 3'b000} + {2'b00, q_rpm_ff[12:0], 1'b0};
      end
      rpm_now = stopped_ff ? 16'd0 : rpm_calc;

      if (stopped_ff) begin
         dwell_target = dwell_base_ff;
      end else if (q_lead_ff >= {{(QW-16){1'b0}}, dwell_base_ff}) begin
         dwell_target = 16'd0;
      end else begin
         dwell_target = dwell_base_ff - q_lead_ff[15:0];
      end

      band_hit   = 1'b1;
      band_spark = spark_ff;
      if (rpm_now >= itc_pkg::BAND_LOW_0 && rpm_now < itc_pkg::BAND_LOW_1) begin
         band_spark = itc_pkg::SPARK_BAND_0;
      end else if (rpm_now >= itc_pkg::BAND_LOW_1 && rpm_now < itc_pkg::BAND_LOW_2) begin
         band_spark = itc_pkg::SPARK_BAND_1;
      end else if (rpm_now >= itc_pkg::BAND_LOW_2 && rpm_now < itc_pkg::BAND_LOW_3) begin
         band_spark = itc_pkg::SPARK_BAND_2;
      end else if (rpm_now >= itc_pkg::BAND_LOW_3 && rpm_now < itc_pkg::BAND_LOW_4) begin
         band_spark = itc_pkg::SPARK_BAND_3;
      end else if (rpm_now >= itc_pkg::BAND_LOW_4 && rpm_now < itc_pkg::BAND_TOP) begin
         band_spark = itc_pkg::SPARK_BAND_4;
      end else begin
         band_hit = 1'b0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itc_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = closes_period ? itc_pkg::ST_DIVIDE : itc_pkg::ST_SETTLE;
            end
         end
         itc_pkg::ST_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = itc_pkg::ST_SETTLE;
            end
         end
         itc_pkg::ST_SETTLE: begin
            if (slot_free) begin
               state_in = itc_pkg::ST_IDLE;
            end
         end
         default: state_in = itc_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_tready    = (state_ff == itc_pkg::ST_IDLE);
      timer_in      = timer_ff;
      running_in    = running_ff;
      period_in     = period_ff;
      stopped_in    = stopped_ff;
      angle_in      = angle_ff;
      dwell_cmp_in  = dwell_cmp_ff;
      dwell_next_in = dwell_next_ff;
      spark_in      = spark_ff;
      coil_in       = coil_ff;
      charge_in     = charge_ff;
      step_in       = step_ff;
      num_rpm_in    = num_rpm_ff;
      num_lead_in   = num_lead_ff;
      rem_rpm_in    = rem_rpm_ff;
      rem_lead_in   = rem_lead_ff;
      q_rpm_in      = q_rpm_ff;
      q_lead_in     = q_lead_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      inj_high_in   = inj_high_ff;
      inj_low_in    = inj_low_ff;
      dwell_base_in = dwell_base_ff;
      if (csr_valid) begin
         unique case (itc_pkg::csr_index_type'(csr_index))
            itc_pkg::CSR_INJ_HIGH:   inj_high_in   = csr_data;
            itc_pkg::CSR_INJ_LOW:    inj_low_in    = csr_data;
            itc_pkg::CSR_DWELL_BASE: dwell_base_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         itc_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  itc_pkg::OP_TICK: begin
                     if (running_ff) begin
                        timer_in = timer_ff + {{(W-1){1'b0}}, 1'b1};
                        if (timer_in == '0) begin
                           running_in = 1'b0;
                           stopped_in = 1'b1;
                        end
                     end
                  end
                  itc_pkg::OP_ENCODER: begin
                     if (angle_ff < itc_pkg::ANGLE_MAX) begin
                        angle_in = angle_next;
                        if ({6'b0, angle_next} == dwell_cmp_ff && enable_bit && band_hit
                            && !stopped_ff) begin
                           coil_in   = 1'b1;
                           charge_in = charge_ff + 16'd1;
                        end
                        if (angle_next == spark_ff) begin
                           dwell_cmp_in = dwell_next_ff;
                           coil_in      = 1'b0;
                        end
                     end
                  end
                  itc_pkg::OP_INDEX: begin
                     angle_in = '0;
                     timer_in = '0;
                     if (!running_ff) begin
                        running_in = 1'b1;
                     end else begin
                        period_in   = timer_ff;
                        stopped_in  = 1'b0;
                        step_in     = itc_pkg::STEP_W'(itc_pkg::DIV_STEPS - 1);
                        num_rpm_in  = itc_pkg::RPM_DIVIDEND;
                        num_lead_in = itc_pkg::LEAD_DIVIDEND;
                        rem_rpm_in  = '0;
                        rem_lead_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         itc_pkg::ST_DIVIDE: begin
            step_in     = step_ff - {{(itc_pkg::STEP_W-1){1'b0}}, 1'b1};
            num_rpm_in  = {num_rpm_ff[QW-2:0], 1'b0};
            num_lead_in = {num_lead_ff[QW-2:0], 1'b0};
            rem_rpm_in  = ge_rpm ? diff_rpm[W-1:0] : trial_rpm[W-1:0];
            rem_lead_in = ge_lead ? diff_lead[W-1:0] : trial_lead[W-1:0];
            q_rpm_in    = {q_rpm_ff[QW-2:0], ge_rpm};
            q_lead_in   = {q_lead_ff[QW-2:0], ge_lead};
         end
         itc_pkg::ST_SETTLE: begin
            if (slot_free) begin
               coil_in       = coil_ff && !stopped_ff && band_hit;
               spark_in      = band_spark;
               dwell_next_in = dwell_target;
               rsp_valid_in  = 1'b1;
               rsp_data_in.pad            = '0;
               rsp_data_in.coil_on        = coil_in;
               rsp_data_in.injector_on    = ({6'b0, angle_ff} > inj_high_ff)
                                            || ({6'b0, angle_ff} < inj_low_ff);
               rsp_data_in.crank_angle    = {6'b0, angle_ff};
               rsp_data_in.engine_rpm     = rpm_now;
               rsp_data_in.engine_stopped = stopped_ff;
               rsp_data_in.spark_count    = charge_ff;
               rsp_data_in.spark_angle    = band_spark;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itc_pkg::ST_IDLE;
         timer_ff      <= '0;
         running_ff    <= 1'b0;
         period_ff     <= '0;
         stopped_ff    <= 1'b1;
         angle_ff      <= '0;
         dwell_cmp_ff  <= itc_pkg::DWELL_RESET;
         dwell_next_ff <= itc_pkg::DWELL_RESET;
         spark_ff      <= itc_pkg::SPARK_RESET;
         coil_ff       <= 1'b0;
         charge_ff     <= '0;
         inj_high_ff   <= itc_pkg::INJ_HIGH_RESET;
         inj_low_ff    <= itc_pkg::INJ_LOW_RESET;
         dwell_base_ff <= itc_pkg::DWELL_BASE_RESET;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         timer_ff      <= timer_in;
         running_ff    <= running_in;
         period_ff     <= period_in;
         stopped_ff    <= stopped_in;
         angle_ff      <= angle_in;
         dwell_cmp_ff  <= dwell_cmp_in;
         dwell_next_ff <= dwell_next_in;
         spark_ff      <= spark_in;
         coil_ff       <= coil_in;
         charge_ff     <= charge_in;
         inj_high_ff   <= inj_high_in;
         inj_low_ff    <= inj_low_in;
         dwell_base_ff <= dwell_base_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_rpm_ff  <= num_rpm_in;
      num_lead_ff <= num_lead_in;
      rem_rpm_ff  <= rem_rpm_in;
      rem_lead_ff <= rem_lead_in;
      q_rpm_ff    <= q_rpm_in;
      q_lead_ff   <= q_lead_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/itc_checker.sv @@
// Port-level checks for the ignition timing controller, bound to the top level.
// Depends on itc_pkg for the result beat layout and angle limits.
module itc_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   itc_pkg::rsp_type rsp_view;
   assign rsp_view = rsp_tdata;

   // No result beat may be pending right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A stalled result beat keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // The block works on one event at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("event accepted while busy");

   // A stopped engine reports zero speed and an idle coil.
   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_view.engine_stopped |->
         rsp_view.engine_rpm == 16'd0 && !rsp_view.coil_on)
      else $error("stopped engine shows speed or coil drive");

   // Spark angle stays in its band table and the crank angle saturates.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_view.spark_angle >= itc_pkg::SPARK_MIN
         && rsp_view.spark_angle <= itc_pkg::SPARK_MAX
         && rsp_view.crank_angle <= {6'b0, itc_pkg::ANGLE_MAX})
      else $error("angle out of range");

endmodule

bind ignition_timing_controller_core itc_port_checker u_itc_checker (.*);

@@ test/itc_checker.sv @@
// Checker for the ignition timing controller: watches the event, result and register channels,
// predicts every result beat from its own copy of the engine state and compares field by field.
// Depends on itc_pkg for the opcode and register enums and the result beat layout.
module itc_checker #(
   parameter int COUNTER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SPEED_NUM   = 11250000;
   localparam int unsigned LEAD_NUM    = 337500;
   localparam int unsigned ANGLE_LIMIT = 719;

   logic [15:0]              inj_high, inj_low, dwell_base;
   logic [COUNTER_WIDTH-1:0] period_count, last_period;
   bit                       counting, stopped, band_ok, coil;
   logic [15:0]              angle, speed, dwell_pending, dwell_target, charges;
   logic [9:0]               spark_target;
   itc_pkg::rsp_type         beat_q[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // Applies one event to the engine copy and forms the result beat it should produce.
   task automatic step_engine(input logic [1:0] op, input bit enable,
                              output itc_pkg::rsp_type res);
      int unsigned quotient, lead;
      case (op)
         itc_pkg::OP_TICK: begin
            if (counting) begin
               period_count = period_count + 1'b1;
               if (period_count == '0) begin
                  counting = 1'b0;
                  stopped  = 1'b1;
                  speed    = '0;
               end
            end
         end
         itc_pkg::OP_ENCODER: begin
            if (angle < ANGLE_LIMIT) begin
               angle = angle + 1'b1;
               if (angle == dwell_target && enable && band_ok && !stopped) begin
                  coil    = 1'b1;
                  charges = charges + 1'b1;
               end
               if (angle == {6'd0, spark_target}) begin
                  dwell_target = dwell_pending;
                  coil         = 1'b0;
               end
            end
         end
         itc_pkg::OP_INDEX: begin
            angle = '0;
            if (!counting) begin
               period_count = '0;
               counting     = 1'b1;
            end else begin
               last_period  = period_count;
               period_count = '0;
               stopped      = 1'b0;
            end
         end
         default: ;
      endcase

      if (stopped) begin
         coil          = 1'b0;
         speed         = '0;
         dwell_pending = dwell_base;
      end else if (last_period == '0) begin
         speed         = 16'hFFFF;
         dwell_pending = '0;
      end else begin
         quotient = SPEED_NUM / last_period;
         quotient = quotient - quotient % 10;
         lead     = LEAD_NUM / last_period;
         speed    = (quotient > 65535) ? 16'hFFFF : quotient[15:0];
         dwell_pending = (dwell_base > lead) ? dwell_base - lead[15:0] : 16'd0;
      end

      // Spark angle comes from the speed band; outside every band the coil is held off.
      band_ok = 1'b1;
      if (speed >= 250 && speed < 2250)        spark_target = 10'd711;
      else if (speed >= 2250 && speed < 2750)  spark_target = 10'd710;
      else if (speed >= 2750 && speed < 3250)  spark_target = 10'd709;
      else if (speed >= 3250 && speed < 4000)  spark_target = 10'd706;
      else if (speed >= 4000 && speed < 5750)  spark_target = 10'd705;
      else begin
         band_ok = 1'b0;
         coil    = 1'b0;
      end

      res                = '0;
      res.coil_on        = coil;
      res.injector_on    = (angle > inj_high) || (angle < inj_low);
      res.crank_angle    = angle;
      res.engine_rpm     = speed;
      res.engine_stopped = stopped;
      res.spark_count    = charges;
      res.spark_angle    = spark_target;
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      itc_pkg::rsp_type wanted, observed;
      if (reset) begin
         inj_high      = 16'd670;
         inj_low       = 16'd180;
         dwell_base    = 16'd704;
         period_count  = '0;
         last_period   = '0;
         counting      = 1'b0;
         stopped       = 1'b1;
         band_ok       = 1'b0;
         coil          = 1'b0;
         angle         = '0;
         speed         = '0;
         dwell_pending = 16'd615;
         dwell_target  = 16'd615;
         charges       = '0;
         spark_target  = 10'd705;
         beat_q.delete();
      end else begin
         // Results are checked before new events are queued: a result never leaves in the
         // same cycle as the event that causes it.
         if (rsp_tvalid && rsp_tready) begin
            observed = rsp_tdata;
            if (beat_q.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               wanted = beat_q.pop_front();
               check_field("coil_on", wanted.coil_on, observed.coil_on);
               check_field("injector_on", wanted.injector_on, observed.injector_on);
               check_field("crank_angle", wanted.crank_angle, observed.crank_angle);
               check_field("engine_rpm", wanted.engine_rpm, observed.engine_rpm);
               check_field("engine_stopped", wanted.engine_stopped, observed.engine_stopped);
               check_field("spark_count", wanted.spark_count, observed.spark_count);
               check_field("spark_angle", wanted.spark_angle, observed.spark_angle);
               check_field("padding", wanted.pad, observed.pad);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               itc_pkg::CSR_INJ_HIGH:   inj_high   = csr_data;
               itc_pkg::CSR_INJ_LOW:    inj_low    = csr_data;
               itc_pkg::CSR_DWELL_BASE: dwell_base = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            step_engine(req_tuser, req_tdata[0], wanted);
            beat_q.push_back(wanted);
         end
      end
      pending_count <= beat_q.size();
   end

endmodule

@@ test/tb.sv @@
// Top of the ignition timing controller testbench: clock, reset, event and register stimulus,
// ready generation on the result side and the final verdict.
// Depends on itc_pkg, ignition_timing_controller_core and itc_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNTER_WIDTH = 16;
   localparam int CYCLE_LIMIT   = 100_000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = '0;
   logic [15:0] csr_data    = '0;

   int error_count, pending_count;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int calm_cycles = 0;
   int cycle_count = 0;

   ignition_timing_controller_core #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   itc_checker #(
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .error_count(error_count), .pending_count(pending_count)
   );

   always #1 clock = ~clock;

   // Result side ready, with occasional calm stretches in which neither side idles.
   always @(posedge clock) begin
      if (calm_cycles != 0) calm_cycles <= calm_cycles - 1;
      else if ($urandom_range(0, 399) == 0) calm_cycles <= $urandom_range(30, 120);
      rsp_tready <= (calm_cycles != 0) || ($urandom_range(0, 99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Valid is only lowered during an idle gap, so back-to-back beats keep it high.
   task automatic send_event(input logic [1:0] op, input bit enable);
      while (calm_cycles == 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, enable};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic await_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic put_register(input itc_pkg::csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_settings(input logic [15:0] win_high, input logic [15:0] win_low,
                                input logic [15:0] base);
      await_quiet();
      put_register(itc_pkg::CSR_INJ_HIGH, win_high);
      put_register(itc_pkg::CSR_INJ_LOW, win_low);
      put_register(itc_pkg::CSR_DWELL_BASE, base);
      csr_valid <= 1'b0;
   endtask

   // One crank turn: an index pulse, then ticks and encoder pulses mixed at random.
   // A ragged turn also carries stray index pulses, and any turn may carry unused opcodes.
   task automatic run_revolution(input int unsigned ticks, input int unsigned pulses,
                                 input bit ragged);
      int unsigned left_ticks, left_pulses;
      bit enable;
      left_ticks  = ticks;
      left_pulses = pulses;
      send_event(itc_pkg::OP_INDEX, 1'($urandom_range(0, 1)));
      while (left_ticks + left_pulses != 0) begin
         enable = ragged ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) != 0);
         if (ragged && $urandom_range(0, 39) == 0)
            send_event($urandom_range(0, 1) ? OP_UNUSED : itc_pkg::OP_INDEX, enable);
         else if ($urandom_range(0, 199) == 0)
            send_event(OP_UNUSED, enable);
         else if ($urandom_range(1, left_ticks + left_pulses) <= left_ticks) begin
            send_event(itc_pkg::OP_TICK, enable);
            left_ticks--;
         end else begin
            send_event(itc_pkg::OP_ENCODER, enable);
            left_pulses--;
         end
      end
   endtask

   // Short turns under fresh register settings: saturated speeds and short periods.
   task automatic run_blocks(input int count);
      logic [15:0] win_high, win_low, base;
      repeat (count) begin
         case ($urandom_range(0, 3))
            1: begin
               win_high = 16'($urandom_range(0, 719));
               win_low  = 16'($urandom_range(0, 719));
               base     = 16'($urandom_range(0, 180));
            end
            2: begin
               win_high = 16'h0000;
               win_low  = 16'hFFFF;
               base     = 16'hFFFF;
            end
            3: begin
               win_high = 16'($urandom);
               win_low  = 16'($urandom);
               base     = 16'($urandom);
            end
            default: begin
               win_high = 16'($urandom_range(0, 24));
               win_low  = 16'($urandom_range(0, 8));
               base     = 16'($urandom_range(500, 719));
            end
         endcase
         load_settings(win_high, win_low, base);
         run_revolution($urandom_range(0, 40), $urandom_range(0, 20), 1'b0);
         run_revolution($urandom_range(0, 30), $urandom_range(0, 15), 1'b1);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct <= 23;
      rx_idle_pct <= 86;

      // Directed events, first under the reset settings: ignored opcode, tick while the timer
      // is idle, zero period and a speed far above the saturation point; then under extreme register settings.
      send_event(OP_UNUSED, 1'b0);
      send_event(itc_pkg::OP_TICK, 1'b1);
      send_event(itc_pkg::OP_ENCODER, 1'b1);
      send_event(itc_pkg::OP_INDEX, 1'b0);
      send_event(itc_pkg::OP_INDEX, 1'b1);
      send_event(itc_pkg::OP_ENCODER, 1'b1);
      send_event(itc_pkg::OP_TICK, 1'b0);
      send_event(itc_pkg::OP_TICK, 1'b1);
      send_event(itc_pkg::OP_INDEX, 1'b1);
      send_event(OP_UNUSED, 1'b1);
      load_settings(16'h0000, 16'hFFFF, 16'hFFFF);
      send_event(itc_pkg::OP_ENCODER, 1'b0);
      send_event(itc_pkg::OP_ENCODER, 1'b1);
      send_event(itc_pkg::OP_TICK, 1'b1);
      load_settings(16'hFFFF, 16'h0000, 16'h0000);
      send_event(itc_pkg::OP_ENCODER, 1'b1);
      send_event(itc_pkg::OP_INDEX, 1'b0);
      send_event(itc_pkg::OP_ENCODER, 1'b1);
      run_blocks(3);

      await_quiet();
      tx_idle_pct <= 86;
      rx_idle_pct <= 23;
      run_blocks(3);

      await_quiet();
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
      load_settings(16'd670, 16'd180, 16'd704);
      // A full turn: the angle passes the spark angle and saturates, and the period is long
      // enough that the next index pulse yields a speed below the saturation point.
      run_revolution($urandom_range(172, 300), 730, 1'b0);
      run_revolution($urandom_range(0, 40), $urandom_range(0, 20), 1'b0);
      send_event(itc_pkg::OP_INDEX, 1'b1);

      await_quiet();
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/itc_pkg.sv
rtl/ignition_timing_controller_core.sv
rtl/itc_checker.sv
test/itc_checker.sv
test/tb.sv
